// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// clocked assertion on the usual clock and reset names
`define ASSERT_STD(lbl, prop) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ----- hw/rtl/ssc_pkg.sv -----
// shared types, codes and helpers of the seven-segment clock set controller
package ssc_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL       = 2'd0,
    MODE_EDIT_HOURS   = 2'd1,
    MODE_EDIT_MINUTES = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_e;

  typedef enum logic [2:0] {
    REG_LONG_PRESS  = 3'd0,
    REG_SHORT_MIN   = 3'd1,
    REG_REFRESH     = 3'd2,
    REG_BLINK       = 3'd3,
    REG_DIGIT_DWELL = 3'd4
  } reg_idx_e;

  localparam logic [15:0] LongPressRst = 16'd1000;
  localparam logic [15:0] ShortMinRst  = 16'd50;
  localparam logic [15:0] RefreshRst   = 16'd500;
  localparam logic [15:0] BlinkRst     = 16'd300;
  localparam logic [7:0]  DwellRst     = 8'd2;

  localparam logic [7:0] SegBlank = 8'hFF;

  // active-low patterns for digits zero to nine
  localparam logic [7:0] SegTable [10] = '{
    8'h81, 8'hED, 8'h43, 8'h49, 8'h2D, 8'h19, 8'h11, 8'hCD, 8'h01, 8'h09
  };

  typedef struct packed {
    logic [15:0] long_press_time;
    logic [15:0] short_press_min;
    logic [15:0] refresh_period;
    logic [15:0] blink_period;
    logic [7:0]  digit_dwell;
  } cfg_t;

  typedef struct packed {
    logic        active;
    logic        reported;
    logic [15:0] ticks;
  } press_t;

  typedef struct packed {
    mode_e      mode;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic       blink_on;
    logic [1:0] digit;
  } disp_t;

  function automatic logic [15:0] sat_inc16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // tens digit of a six-bit value
  function automatic logic [3:0] tens_of(logic [5:0] v);
    logic [3:0] t;
    if (v >= 6'd60) t = 4'd6;
    else if (v >= 6'd50) t = 4'd5;
    else if (v >= 6'd40) t = 4'd4;
    else if (v >= 6'd30) t = 4'd3;
    else if (v >= 6'd20) t = 4'd2;
    else if (v >= 6'd10) t = 4'd1;
    else t = 4'd0;
    return t;
  endfunction

endpackage

// ----- hw/rtl/ssc_cfg.sv -----
// apb register file for the timing settings
module ssc_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output ssc_pkg::cfg_t cfg_o
);
  import ssc_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_time <= LongPressRst;
      cfg_q.short_press_min <= ShortMinRst;
      cfg_q.refresh_period  <= RefreshRst;
      cfg_q.blink_period    <= BlinkRst;
      cfg_q.digit_dwell     <= DwellRst;
    end else if (psel && penable && pwrite && pready) begin
      unique case (idx)
        REG_LONG_PRESS:  cfg_q.long_press_time <= pwdata[15:0];
        REG_SHORT_MIN:   cfg_q.short_press_min <= pwdata[15:0];
        REG_REFRESH:     cfg_q.refresh_period  <= pwdata[15:0];
        REG_BLINK:       cfg_q.blink_period    <= pwdata[15:0];
        REG_DIGIT_DWELL: cfg_q.digit_dwell     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LONG_PRESS:  prdata = {16'd0, cfg_q.long_press_time};
      REG_SHORT_MIN:   prdata = {16'd0, cfg_q.short_press_min};
      REG_REFRESH:     prdata = {16'd0, cfg_q.refresh_period};
      REG_BLINK:       prdata = {16'd0, cfg_q.blink_period};
      REG_DIGIT_DWELL: prdata = {24'd0, cfg_q.digit_dwell};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

// ----- hw/rtl/ssc_press.sv -----
// press classifier: hold counting and short or long event detection
module ssc_press (
  input  logic             pressed_i,
  input  ssc_pkg::press_t  press_i,
  input  logic [15:0]      long_time_i,
  input  logic [15:0]      short_min_i,
  output ssc_pkg::press_t  press_o,
  output ssc_pkg::event_e  event_o
);
  import ssc_pkg::*;

  always_comb begin
    press_o = press_i;
    event_o = EV_NONE;
    if (pressed_i) begin
      if (!press_i.active) begin
        press_o.active   = 1'b1;
        press_o.reported = 1'b0;
        press_o.ticks    = 16'd0;
      end else begin
        press_o.ticks = sat_inc16(press_i.ticks);
      end
      if (!press_o.reported && press_o.ticks >= long_time_i) begin
        press_o.reported = 1'b1;
        event_o          = EV_LONG;
      end
    end else if (press_i.active) begin
      press_o.active = 1'b0;
      if (!press_i.reported) begin
        press_o.reported = 1'b1;
        if (press_i.ticks >= short_min_i) event_o = EV_SHORT;
      end
    end
  end

endmodule

// ----- hw/rtl/ssc_disp.sv -----
// digit select, segment lookup and blanking of the edited pair
module ssc_disp (
  input  ssc_pkg::disp_t disp_i,
  output logic [7:0]     segments_o,
  output logic [3:0]     digit_enables_o
);
  import ssc_pkg::*;

  logic [5:0] value;
  logic [3:0] tens;
  logic [3:0] ones;
  logic [3:0] digit;
  logic       blank;

  always_comb begin
    value = disp_i.digit[1] ? disp_i.minutes : {1'b0, disp_i.hours};
    tens  = tens_of(value);
    ones  = 4'(value - 6'(tens) * 6'd10);
    digit = disp_i.digit[0] ? ones : tens;
    blank = 1'b0;
    if (!disp_i.blink_on) begin
      if (disp_i.mode == MODE_EDIT_HOURS && !disp_i.digit[1]) blank = 1'b1;
      if (disp_i.mode == MODE_EDIT_MINUTES && disp_i.digit[1]) blank = 1'b1;
    end
    segments_o      = blank ? SegBlank : SegTable[digit];
    digit_enables_o = ~(4'd1 << disp_i.digit);
  end

endmodule

// ----- hw/rtl/seven_segment_clock_set_controller.sv -----
// top level of the seven-segment clock set controller
// path: an accepted tick word goes through the input register, then the result register
// throughput: one word per cycle back to back while result words are taken, set by the single short pass
// between the input register and the result register
// stalls: a held result word blocks the input only once the input register is full
// reset: rst_ni is asynchronous active low and puts counters, mode and timing registers to their reset values
module seven_segment_clock_set_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // tick input: button_level[0], rtc_hours[5:1], rtc_minutes[11:6],
  // rtc_seconds[17:12], zero fill [23:18]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  // result: segments[7:0], digit_enables[11:8], mode[13:12],
  // press kind[15:14], write_strobe[16], write_hours[21:17],
  // write_minutes[27:22], write_seconds[33:28], zero fill [39:34]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata
);
  import ssc_pkg::*;

  // (reset values take effect at once, without waiting for a clock edge)
  cfg_t cfg;

  ssc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register
  logic        in_valid_q;
  logic [17:0] in_data_q;
  logic        advance;

  assign advance       = in_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata[17:0];
    end
  end

  logic       pressed;
  logic [4:0] rtc_h;
  logic [5:0] rtc_m;
  logic [5:0] rtc_s;

  assign pressed = !in_data_q[0];
  assign rtc_h   = in_data_q[5:1];
  assign rtc_m   = in_data_q[11:6];
  assign rtc_s   = in_data_q[17:12];

  // tick state
  mode_e       mode_q, mode_d;
  logic [4:0]  edit_h_q, edit_h_d;
  logic [5:0]  edit_m_q, edit_m_d;
  logic [5:0]  edit_s_q, edit_s_d;
  logic [4:0]  shown_h_q, shown_h_d;
  logic [5:0]  shown_m_q, shown_m_d;
  press_t      press_q, press_d;
  logic [15:0] refresh_q, refresh_d;
  logic [15:0] blink_q, blink_d;
  logic        blink_on_q, blink_on_d;
  logic [1:0]  scan_digit_q, scan_digit_d;
  logic [7:0]  scan_ticks_q, scan_ticks_d;

  event_e      ev;

  ssc_press u_press (
    .pressed_i   (pressed),
    .press_i     (press_q),
    .long_time_i (cfg.long_press_time),
    .short_min_i (cfg.short_press_min),
    .press_o     (press_d),
    .event_o     (ev)
  );

  logic        strobe;
  logic [4:0]  wr_h;
  logic [5:0]  wr_m;
  logic [5:0]  wr_s;
  logic [4:0]  h_inc;
  logic [5:0]  m_inc;
  logic [15:0] blink_inc;
  logic [7:0]  scan_inc;

  always_comb begin
    mode_d    = mode_q;
    edit_h_d  = edit_h_q;
    edit_m_d  = edit_m_q;
    edit_s_d  = edit_s_q;
    shown_h_d = shown_h_q;
    shown_m_d = shown_m_q;
    refresh_d = refresh_q;
    strobe    = 1'b0;
    wr_h      = 5'd0;
    wr_m      = 6'd0;
    wr_s      = 6'd0;

    // increments wrap by one subtract, the sum stays below twice the modulus
    h_inc = edit_h_q + 5'd1;
    if (edit_h_q >= 5'd23) h_inc = edit_h_q - 5'd23;
    m_inc = edit_m_q + 6'd1;
    if (edit_m_q >= 6'd59) m_inc = edit_m_q - 6'd59;

    // mode handling on the press event
    unique case (ev)
      EV_LONG: begin
        unique case (mode_q)
          MODE_EDIT_HOURS: mode_d = MODE_EDIT_MINUTES;
          MODE_EDIT_MINUTES: begin
            strobe    = 1'b1;
            wr_h      = edit_h_q;
            wr_m      = edit_m_q;
            wr_s      = edit_s_q;
            shown_h_d = edit_h_q;
            shown_m_d = edit_m_q;
            refresh_d = 16'd0;
            mode_d    = MODE_NORMAL;
          end
          default: begin
            // entering set-hour takes a snapshot of the live clock
            edit_h_d = rtc_h;
            edit_m_d = rtc_m;
            edit_s_d = rtc_s;
            mode_d   = MODE_EDIT_HOURS;
          end
        endcase
      end
      EV_SHORT: begin
        if (mode_q == MODE_EDIT_HOURS) begin
          edit_h_d = h_inc;
        end else if (mode_q == MODE_EDIT_MINUTES) begin
          edit_m_d = m_inc;
          edit_s_d = 6'd0;
        end
      end
      default: ;
    endcase

    // periodic resample of the shown time in normal mode
    if (!strobe) begin
      refresh_d = sat_inc16(refresh_q);
      if (mode_d != MODE_EDIT_HOURS && mode_d != MODE_EDIT_MINUTES &&
          refresh_d >= cfg.refresh_period) begin
        shown_h_d = rtc_h;
        shown_m_d = rtc_m;
        refresh_d = 16'd0;
      end
    end

    // blink flag
    blink_inc  = sat_inc16(blink_q);
    blink_d    = blink_inc;
    blink_on_d = blink_on_q;
    if (blink_inc >= cfg.blink_period) begin
      blink_d    = 16'd0;
      blink_on_d = !blink_on_q;
    end

    // scan advance, the current digit is shown before it moves on
    scan_inc     = scan_ticks_q + 8'd1;
    scan_ticks_d = scan_inc;
    scan_digit_d = scan_digit_q;
    if (scan_inc >= cfg.digit_dwell) begin
      scan_ticks_d = 8'd0;
      scan_digit_d = scan_digit_q + 2'd1;
    end
  end

  // display from the updated state
  disp_t      disp;
  logic [7:0] segments;
  logic [3:0] digit_en;

  always_comb begin
    disp.mode     = mode_d;
    disp.blink_on = blink_on_d;
    disp.digit    = scan_digit_q;
    if (mode_d == MODE_EDIT_HOURS || mode_d == MODE_EDIT_MINUTES) begin
      disp.hours   = edit_h_d;
      disp.minutes = edit_m_d;
    end else begin
      disp.hours   = shown_h_d;
      disp.minutes = shown_m_d;
    end
  end

  ssc_disp u_disp (
    .disp_i          (disp),
    .segments_o      (segments),
    .digit_enables_o (digit_en)
  );

  // state registers move once per word handed to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_NORMAL;
      edit_h_q     <= 5'd0;
      edit_m_q     <= 6'd0;
      edit_s_q     <= 6'd0;
      shown_h_q    <= 5'd0;
      shown_m_q    <= 6'd0;
      press_q      <= '0;
      refresh_q    <= 16'hFFFF;
      blink_q      <= 16'd0;
      blink_on_q   <= 1'b1;
      scan_digit_q <= 2'd0;
      scan_ticks_q <= 8'd0;
    end else if (advance) begin
      mode_q       <= mode_d;
      edit_h_q     <= edit_h_d;
      edit_m_q     <= edit_m_d;
      edit_s_q     <= edit_s_d;
      shown_h_q    <= shown_h_d;
      shown_m_q    <= shown_m_d;
      press_q      <= press_d;
      refresh_q    <= refresh_d;
      blink_q      <= blink_d;
      blink_on_q   <= blink_on_d;
      scan_digit_q <= scan_digit_d;
      scan_ticks_q <= scan_ticks_d;
    end
  end

  // result register
  logic        out_valid_q;
  logic [39:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {6'd0, wr_s, wr_m, wr_h, strobe, ev, mode_d, digit_en, segments};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- hw/rtl/ssc_checker.sv -----
// port-level checker for the seven-segment clock set controller and its bind
`include "assert_macros.svh"

module ssc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  import ssc_pkg::*;

  // a stalled result word holds
  `ASSERT_STD(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

  // exactly one digit lit in every result word
  `ASSERT_STD(a_one_digit, m_axis_tvalid |-> $countones(m_axis_tdata[11:8]) == 3)

  // write fields are zero without the strobe
  `ASSERT_STD(a_write_quiet, m_axis_tvalid && !m_axis_tdata[16] |-> m_axis_tdata[33:17] == 17'd0)

  // the strobe only comes with a long press that returns to normal mode
  `ASSERT_STD(a_strobe_long, m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[15:14] == EV_LONG && m_axis_tdata[13:12] == MODE_NORMAL)

  // unused mode code never shows
  `ASSERT_STD(a_mode_range, m_axis_tvalid |-> m_axis_tdata[13:12] <= MODE_EDIT_MINUTES)

endmodule

bind seven_segment_clock_set_controller ssc_checker u_ssc_checker (.*);

// ----- bench/tb_seven_segment_clock_set_controller.sv -----
// self-checking bench for the seven-segment clock set controller, tick words in, display words checked
`timescale 1ns / 1ps

module tb_seven_segment_clock_set_controller;
  import ssc_pkg::*;

  localparam int     ClkHalf       = 4;
  localparam int     ResetCycles   = 10;
  // pipeline of input register and result register; wait_drained adds slack on top before touching registers
  localparam int     Latency       = 2;
  localparam int     RandomTicks   = 350;
  localparam int     HoldoffCycles = 300;
  localparam longint CycleLimit    = 1_000_000;

  // active-low glyphs for digits zero to nine, G F A B E D C DP
  localparam logic [7:0] DigitGlyph [10] = '{
    8'h81, 8'hED, 8'h43, 8'h49, 8'h2D, 8'h19, 8'h11, 8'hCD, 8'h01, 8'h09
  };

  // one tick word as it sits in s_axis_tdata, lowest field last
  typedef struct packed {
    logic [5:0] rtc_seconds;
    logic [5:0] rtc_minutes;
    logic [4:0] rtc_hours;
    logic       button_level;
  } tick_word_t;

  // one display word as it sits in m_axis_tdata, lowest field last
  typedef struct packed {
    logic [5:0] write_seconds;
    logic [5:0] write_minutes;
    logic [4:0] write_hours;
    logic       write_strobe;
    event_e     press_kind;
    mode_e      shown_mode;
    logic [3:0] digit_enables;
    logic [7:0] segments;
  } disp_word_t;

  localparam int TickW = $bits(tick_word_t);
  localparam int DispW = $bits(disp_word_t);

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [4:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  seven_segment_clock_set_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow of the block: timing registers and clock/display state
  // ---------------------------------------------------------------------------
  cfg_t       timing;
  mode_e      cur_mode;
  logic [4:0] edit_h, show_h;
  logic [5:0] edit_m, edit_s, show_m;
  logic       btn_held, btn_done, blink_lit;
  logic [15:0] hold_ticks, since_refresh, blink_count;
  logic [1:0] scan_pos;
  logic [7:0] dwell_count;

  tick_word_t tick_backlog [$];      // ticks waiting for the sender
  disp_word_t pending_displays [$];  // display words predicted, not yet seen

  int ticks_queued   = 0;
  int ticks_taken    = 0;
  int words_seen     = 0;
  int mismatch_count = 0;
  int holdoff_asked  = 0;
  int holdoff_served = 0;

  function automatic logic [15:0] bump16(input logic [15:0] v);
    return (&v) ? v : v + 16'd1;
  endfunction

  task automatic clear_shadow();
    timing.long_press_time = LongPressRst;
    timing.short_press_min = ShortMinRst;
    timing.refresh_period  = RefreshRst;
    timing.blink_period    = BlinkRst;
    timing.digit_dwell     = DwellRst;
    cur_mode      = MODE_NORMAL;
    edit_h        = '0;
    edit_m        = '0;
    edit_s        = '0;
    show_h        = '0;
    show_m        = '0;
    btn_held      = 1'b0;
    btn_done      = 1'b0;
    hold_ticks    = '0;
    // all ones so the first normal-mode tick samples the clock
    since_refresh = 16'hFFFF;
    blink_count   = '0;
    blink_lit     = 1'b1;
    scan_pos      = '0;
    dwell_count   = '0;
  endtask

  // one millisecond tick: classify the button, act on it, refresh, blink, scan
  task automatic advance_tick(input tick_word_t t);
    disp_word_t r;
    logic       blank;
    logic [4:0] h;
    logic [5:0] m;
    logic [5:0] val;
    logic [3:0] dig;
    r     = '0;
    blank = 1'b0;

    // press classifier, a pin level of zero means pressed
    if (!t.button_level) begin
      if (!btn_held) begin
        btn_held   = 1'b1;
        btn_done   = 1'b0;
        hold_ticks = '0;
      end else begin
        hold_ticks = bump16(hold_ticks);
      end
      if (!btn_done && hold_ticks >= timing.long_press_time) begin
        btn_done     = 1'b1;
        r.press_kind = EV_LONG;
      end
    end else if (btn_held) begin
      btn_held = 1'b0;
      if (!btn_done) begin
        btn_done = 1'b1;
        if (hold_ticks >= timing.short_press_min) r.press_kind = EV_SHORT;
      end
    end

    // long press steps the mode, short press edits the selected field
    if (r.press_kind == EV_LONG) begin
      case (cur_mode)
        MODE_EDIT_HOURS: cur_mode = MODE_EDIT_MINUTES;
        MODE_EDIT_MINUTES: begin
          r.write_strobe  = 1'b1;
          r.write_hours   = edit_h;
          r.write_minutes = edit_m;
          r.write_seconds = edit_s;
          show_h          = edit_h;
          show_m          = edit_m;
          since_refresh   = '0;
          cur_mode        = MODE_NORMAL;
        end
        default: begin
          edit_h   = t.rtc_hours;
          edit_m   = t.rtc_minutes;
          edit_s   = t.rtc_seconds;
          cur_mode = MODE_EDIT_HOURS;
        end
      endcase
    end else if (r.press_kind == EV_SHORT) begin
      if (cur_mode == MODE_EDIT_HOURS) begin
        edit_h = 5'((edit_h + 1) % 24);
      end else if (cur_mode == MODE_EDIT_MINUTES) begin
        edit_m = 6'((edit_m + 1) % 60);
        edit_s = '0;
      end
    end

    // shown time follows the clock in normal mode only
    if (!r.write_strobe) since_refresh = bump16(since_refresh);
    if (cur_mode == MODE_NORMAL && !r.write_strobe &&
        since_refresh >= timing.refresh_period) begin
      show_h        = t.rtc_hours;
      show_m        = t.rtc_minutes;
      since_refresh = '0;
    end

    blink_count = bump16(blink_count);
    if (blink_count >= timing.blink_period) begin
      blink_count = '0;
      blink_lit   = ~blink_lit;
    end

    // scan output from the updated state, edited pair dark while blink is off
    if (cur_mode == MODE_EDIT_HOURS || cur_mode == MODE_EDIT_MINUTES) begin
      h = edit_h;
      m = edit_m;
      if (!blink_lit) begin
        if (cur_mode == MODE_EDIT_HOURS && scan_pos < 2'd2) blank = 1'b1;
        if (cur_mode == MODE_EDIT_MINUTES && scan_pos >= 2'd2) blank = 1'b1;
      end
    end else begin
      h = show_h;
      m = show_m;
    end
    val = (scan_pos < 2'd2) ? {1'b0, h} : m;
    dig = 4'(scan_pos[0] ? val % 10 : val / 10);
    r.segments      = blank ? SegBlank : DigitGlyph[dig];
    r.digit_enables = ~(4'b0001 << scan_pos);
    r.shown_mode    = cur_mode;
    pending_displays.push_back(r);

    dwell_count = dwell_count + 8'd1;
    if (dwell_count >= timing.digit_dwell) begin
      dwell_count = '0;
      scan_pos    = scan_pos + 2'd1;
    end
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("MISMATCH word %0d %s: got %0h want %0h", words_seen, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // sender: bursts of random length, random gaps between them
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      // predict at the edge the word is taken
      if (s_axis_tvalid && s_axis_tready) begin
        advance_tick(tick_word_t'(s_axis_tdata[TickW-1:0]));
        ticks_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (tick_backlog.size() != 0) begin
          s_axis_tdata  <= {(24 - TickW)'(0), tick_backlog.pop_front()};
          s_axis_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            // every fourth burst or so is a long stretch with no idling
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20);
            gap_left   = $urandom_range(0, 6);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall density changes between random stretches, plus long holdoffs
  // ---------------------------------------------------------------------------
  int holdoff_left = 0;
  int pattern_left = 0;
  int stall_pct    = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      m_axis_tready <= 1'b0;
    end else if (holdoff_served != holdoff_asked) begin
      holdoff_served = holdoff_asked;
      holdoff_left   = HoldoffCycles;
      m_axis_tready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(30, 150);
        case ($urandom_range(3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end else begin
        pattern_left--;
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // checker: every display word against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_words
    disp_word_t got;
    disp_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = disp_word_t'(m_axis_tdata[DispW-1:0]);
      if (pending_displays.size() == 0) begin
        note_mismatch("word with nothing predicted", m_axis_tdata[31:0], '0);
      end else begin
        want = pending_displays.pop_front();
        if (got.segments !== want.segments)
          note_mismatch("segments", 32'(got.segments), 32'(want.segments));
        if (got.digit_enables !== want.digit_enables)
          note_mismatch("digit_enables", 32'(got.digit_enables),
                        32'(want.digit_enables));
        if (got.shown_mode !== want.shown_mode)
          note_mismatch("mode", 32'(got.shown_mode), 32'(want.shown_mode));
        if (got.press_kind !== want.press_kind)
          note_mismatch("press kind", 32'(got.press_kind), 32'(want.press_kind));
        if (got.write_strobe !== want.write_strobe)
          note_mismatch("write_strobe", 32'(got.write_strobe), 32'(want.write_strobe));
        if (got.write_hours !== want.write_hours)
          note_mismatch("write_hours", 32'(got.write_hours), 32'(want.write_hours));
        if (got.write_minutes !== want.write_minutes)
          note_mismatch("write_minutes", 32'(got.write_minutes),
                        32'(want.write_minutes));
        if (got.write_seconds !== want.write_seconds)
          note_mismatch("write_seconds", 32'(got.write_seconds),
                        32'(want.write_seconds));
      end
      words_seen++;
    end
  end

  longint cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d words seen", cycle_count, words_seen);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic apb_write(input reg_idx_e idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    // register takes the value at this edge
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LONG_PRESS:  timing.long_press_time = value[15:0];
      REG_SHORT_MIN:   timing.short_press_min = value[15:0];
      REG_REFRESH:     timing.refresh_period  = value[15:0];
      REG_BLINK:       timing.blink_period    = value[15:0];
      REG_DIGIT_DWELL: timing.digit_dwell     = value[7:0];
      default: ;
    endcase
  endtask

  task automatic program_timing(input int lp, input int sp, input int rp,
                                input int bp, input int dw);
    apb_write(REG_LONG_PRESS, 32'(lp));
    apb_write(REG_SHORT_MIN, 32'(sp));
    apb_write(REG_REFRESH, 32'(rp));
    apb_write(REG_BLINK, 32'(bp));
    apb_write(REG_DIGIT_DWELL, 32'(dw));
  endtask

  task automatic queue_fixed(input logic level, input logic [4:0] hh,
                             input logic [5:0] mm, input logic [5:0] ss);
    tick_word_t w;
    w.button_level = level;
    w.rtc_hours    = hh;
    w.rtc_minutes  = mm;
    w.rtc_seconds  = ss;
    tick_backlog.push_back(w);
    ticks_queued++;
  endtask

  task automatic queue_tick(input logic level);
    queue_fixed(level, 5'($urandom_range(23)), 6'($urandom_range(59)),
                6'($urandom_range(59)));
  endtask

  task automatic queue_press(input int held, input int released);
    repeat (held) queue_tick(1'b0);
    repeat (released) queue_tick(1'b1);
  endtask

  // mostly clean presses of each kind, some raw pin noise in between
  task automatic queue_press_mix(input int n_ticks);
    int start;
    int kind;
    int lp;
    int sp;
    lp    = timing.long_press_time;
    sp    = timing.short_press_min;
    start = ticks_queued;
    while (ticks_queued - start < n_ticks) begin
      kind = $urandom_range(9);
      if (kind < 3)
        queue_press(lp + 1 + $urandom_range(3), $urandom_range(1, 5));
      else if (kind < 6 && sp < lp)
        queue_press(sp + 1 + $urandom_range(lp - sp - 1), $urandom_range(1, 5));
      else if (kind < 8 && sp > 0)
        queue_press($urandom_range(1, sp), $urandom_range(1, 5));
      else
        repeat ($urandom_range(1, 8)) queue_tick(1'($urandom_range(1)));
    end
  endtask

  // every tick taken and every display word back, then a quiet wait before returning
  task automatic wait_drained();
    while (ticks_taken != ticks_queued || pending_displays.size() != 0)
      @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : sequence_main
    int random_done;
    int phase;
    int lp;
    int sp;
    clear_shadow();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // first tick at reset timing samples the clock at once
    queue_fixed(1'b1, 5'd23, 6'd59, 6'd59);
    wait_drained();

    // directed walk through every mode with tiny thresholds
    program_timing(3, 1, 1, 2, 1);
    queue_fixed(1'b1, 5'd31, 6'd63, 6'd63);  // out-of-range clock shown as given
    queue_fixed(1'b1, 5'd0, 6'd0, 6'd0);
    queue_fixed(1'b0, 5'd0, 6'd0, 6'd0);     // press too short to count
    queue_fixed(1'b1, 5'd0, 6'd0, 6'd0);
    repeat (4) queue_fixed(1'b0, 5'd23, 6'd59, 6'd59);  // long: snapshot into set-hour
    queue_fixed(1'b1, 5'd1, 6'd2, 6'd3);
    repeat (2) queue_fixed(1'b0, 5'd1, 6'd2, 6'd3);     // short: hours wrap to zero
    queue_fixed(1'b1, 5'd1, 6'd2, 6'd3);
    repeat (4) queue_fixed(1'b0, 5'd4, 6'd5, 6'd6);     // long: on to set-minute
    queue_fixed(1'b1, 5'd4, 6'd5, 6'd6);
    repeat (2) queue_fixed(1'b0, 5'd7, 6'd8, 6'd9);     // short: minutes wrap, seconds cleared
    queue_fixed(1'b1, 5'd7, 6'd8, 6'd9);
    repeat (4) queue_fixed(1'b0, 5'd10, 6'd11, 6'd12);  // long: write strobe, back to normal
    queue_fixed(1'b1, 5'd10, 6'd11, 6'd12);
    wait_drained();

    // random phases, the first one at the lowest settings
    random_done = 0;
    phase       = 0;
    while (random_done < RandomTicks) begin
      if (phase == 0) begin
        program_timing(1, 0, 1, 1, 1);
      end else begin
        lp = $urandom_range(3, 40);
        sp = $urandom_range(0, lp);
        program_timing(lp, sp, $urandom_range(1, 30), $urandom_range(1, 20),
                       $urandom_range(1, 6));
      end
      random_done -= ticks_queued;
      queue_press_mix($urandom_range(120, 260));
      random_done += ticks_queued;
      // receiver holds off while the sender keeps offering, the block backs up
      if (phase == 1) holdoff_asked++;
      wait_drained();
      phase++;
    end

    // wide settings: counters past eight bits
    sp = $urandom_range(256, 270);
    lp = $urandom_range(sp + 4, 300);
    program_timing(lp, sp, $urandom_range(260, 500), $urandom_range(257, 400),
                   $urandom_range(100, 255));
    queue_press(lp + 2, 10);                                // long: into set-hour
    queue_press(sp + 1 + $urandom_range(lp - sp - 1), 10);  // short: hours step
    queue_press(lp + 1, 10);                                // long: into set-minute
    queue_press(lp + 3, 60);                                // long: write strobe
    wait_drained();

    // top of every range, nothing but the scan should move
    program_timing(65535, 65535, 65535, 65535, 255);
    queue_press(100, 20);
    repeat (60) queue_tick(1'($urandom_range(1)));
    wait_drained();

    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
